// ===== hw/rtl/tridiagonal_system_solver_unit_defines.svh =====
// Assertion helpers for the tridiagonal solver.
`ifndef TRIDIAGONAL_SYSTEM_SOLVER_UNIT_DEFINES_SVH
`define TRIDIAGONAL_SYSTEM_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication
`define TSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tss assertion failed");

// next-cycle implication
`define TSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tss assertion failed");

`endif

// ===== hw/rtl/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// Types, codes and helpers shared by the tridiagonal solver modules.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned TssMaxRows  = 64;
  localparam int unsigned TssFracBits = 16;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_ZERO_PIVOT = 2'd1,
    ST_OVERFLOW   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_CHECK,
    BK_DIV_G,
    BK_MUL_G,
    BK_BET,
    BK_MUL_D,
    BK_NUM,
    BK_DIV_D,
    BK_FIN,
    BK_BS_RD,
    BK_BS_MUL,
    BK_BS_OUT
  } bk_state_e;

  typedef struct packed {
    logic signed [31:0] coef_lower;
    logic signed [31:0] coef_diag;
    logic signed [31:0] coef_upper;
    logic signed [31:0] rhs_value;
    logic               last_row;
  } row_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic        [5:0]  row_index;
    status_e            status;
    logic               last_result;
  } res_t;

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      return -32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== hw/rtl/tss_front.sv =====
// ----------------------------------------------------------------------------
// tss_front
// Row intake: two-word queue that decouples the command port from the
// elimination engine.
// ----------------------------------------------------------------------------
module tss_front
  import tss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  row_t row_i,
  output logic busy_o,
  input  logic pop_i,
  output logic avail_o,
  output row_t head_o
);

  row_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy_o  = (cnt_q == 2'd2);
  assign push    = start_i && !busy_o;
  assign avail_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop_i && avail_o) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i && avail_o};
    end
  end

endmodule

// ===== hw/rtl/tss_div.sv =====
// ----------------------------------------------------------------------------
// tss_div
// Radix-2 restoring divider: (a << FRAC_BITS) / b, truncated toward zero,
// saturated to 32 bits. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module tss_div
  import tss_pkg::*;
#(
  parameter int unsigned FRAC_BITS = TssFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic               done_o,
  output logic signed [31:0] q_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] num_q;
  logic [31:0]   den_q;
  logic [31:0]   rem_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic          done_q;

  logic [31:0]   mag_a, mag_b;
  logic [32:0]   trial;
  logic          qbit;
  logic [32:0]   diff;

  assign mag_a = a_i[31] ? 32'(-a_i) : 32'(a_i);
  assign mag_b = b_i[31] ? 32'(-b_i) : 32'(b_i);
  assign trial = {rem_q, num_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign qbit  = !diff[32];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag_a, {FRAC_BITS{1'b0}}};
      den_q <= mag_b;
      rem_q <= '0;
      neg_q <= a_i[31] ^ b_i[31];
    end else if (cnt_q != '0) begin
      rem_q <= qbit ? diff[31:0] : trial[31:0];
      num_q <= {num_q[NW-2:0], qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(NW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // sign and clamp the unsigned quotient
  always_comb begin
    if (neg_q) begin
      if (num_q > NW'(33'h1_0000_0000 >> 1)) begin
        q_o = -32'sh8000_0000;
      end else begin
        q_o = 32'(-num_q);
      end
    end else begin
      if (num_q > NW'(32'h7FFF_FFFF)) begin
        q_o = 32'sh7FFF_FFFF;
      end else begin
        q_o = num_q[31:0];
      end
    end
  end

  assign done_o = done_q;

endmodule

// ===== hw/rtl/tss_back.sv =====
// ----------------------------------------------------------------------------
// tss_back
// Elimination and back-substitution engine: forward step per row, factor
// stores, descending solution readout and error results.
// ----------------------------------------------------------------------------
`include "tridiagonal_system_solver_unit_defines.svh"

module tss_back
  import tss_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = TssMaxRows,
  parameter int unsigned FRAC_BITS = TssFracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic avail_i,
  input  row_t head_i,
  output logic pop_o,
  output logic res_valid_o,
  output res_t res_o
);

  localparam int unsigned RW = $clog2(MAX_ROWS + 1);
  localparam int unsigned IW = $clog2(MAX_ROWS);
  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

  bk_state_e state_q, state_d;

  row_t               cur_q;
  status_e            err_q;
  logic [RW-1:0]      rows_q;
  logic signed [31:0] pivot_q, pvup_q, pdel_q, g_q, bet_q, x_q;
  logic signed [63:0] prod_q;
  logic [IW-1:0]      idx_q;
  logic               first_q;
  logic signed [31:0] drd_q, grd_q;
  res_t               res_q;
  logic               res_valid_q;

  logic signed [31:0] gamma_mem [MAX_ROWS];
  logic signed [31:0] delta_mem [MAX_ROWS];

  logic               div_start, div_done;
  logic signed [31:0] div_a, div_b, div_q;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] rnd;
  logic signed [31:0] mres, bet, num, xnew;
  logic [IW-1:0]      widx, gidx;

  tss_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .a_i    (div_a),
    .b_i    (div_b),
    .done_o (div_done),
    .q_o    (div_q)
  );

  assign rnd  = (prod_q + Half) >>> FRAC_BITS;
  assign mres = sat64(rnd);
  assign bet  = sat33({cur_q.coef_diag[31], cur_q.coef_diag} - {mres[31], mres});
  assign num  = sat33({cur_q.rhs_value[31], cur_q.rhs_value} - {mres[31], mres});
  assign xnew = first_q ? drd_q : sat33({drd_q[31], drd_q} - {mres[31], mres});
  assign widx = rows_q[IW-1:0];
  assign gidx = idx_q + IW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:  if (avail_i) state_d = BK_CHECK;
      BK_CHECK: begin
        if (err_q != ST_OK || rows_q == RW'(MAX_ROWS)) begin
          state_d = BK_FIN;
        end else if (rows_q == '0) begin
          state_d = (cur_q.coef_diag == '0) ? BK_FIN : BK_DIV_D;
        end else begin
          state_d = BK_DIV_G;
        end
      end
      BK_DIV_G:  if (div_done) state_d = BK_MUL_G;
      BK_MUL_G:  state_d = BK_BET;
      BK_BET:    state_d = (bet == '0) ? BK_FIN : BK_MUL_D;
      BK_MUL_D:  state_d = BK_NUM;
      BK_NUM:    state_d = BK_DIV_D;
      BK_DIV_D:  if (div_done) state_d = BK_FIN;
      BK_FIN: begin
        if (!cur_q.last_row || err_q != ST_OK) begin
          state_d = BK_IDLE;
        end else begin
          state_d = BK_BS_RD;
        end
      end
      BK_BS_RD:  state_d = BK_BS_MUL;
      BK_BS_MUL: state_d = BK_BS_OUT;
      BK_BS_OUT: state_d = (idx_q == '0) ? BK_IDLE : BK_BS_RD;
      default:   state_d = BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_a     = pvup_q;
    div_b     = pivot_q;
    mul_a     = cur_q.coef_lower;
    mul_b     = g_q;
    case (state_q)
      BK_IDLE:  pop_o = avail_i;
      BK_CHECK: begin
        if (err_q == ST_OK && rows_q != RW'(MAX_ROWS)) begin
          if (rows_q == '0) begin
            div_start = (cur_q.coef_diag != '0);
            div_a     = cur_q.rhs_value;
            div_b     = cur_q.coef_diag;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      BK_MUL_D: mul_b = pdel_q;
      BK_NUM: begin
        div_start = 1'b1;
        div_a     = num;
        div_b     = bet_q;
      end
      BK_BS_MUL: begin
        mul_a = grd_q;
        mul_b = x_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    drd_q  <= delta_mem[idx_q];
    grd_q  <= gamma_mem[gidx];
    if (state_q == BK_IDLE) begin
      cur_q <= head_i;
    end
    if (state_q == BK_CHECK) begin
      bet_q <= cur_q.coef_diag;
    end
    if (state_q == BK_DIV_G && div_done) begin
      g_q              <= div_q;
      gamma_mem[widx]  <= div_q;
    end
    if (state_q == BK_BET) begin
      bet_q <= bet;
    end
    if (state_q == BK_DIV_D && div_done) begin
      delta_mem[widx] <= div_q;
      pdel_q          <= div_q;
    end
    if (state_q == BK_BS_OUT) begin
      x_q <= xnew;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      err_q       <= ST_OK;
      rows_q      <= '0;
      pivot_q     <= '0;
      pvup_q      <= '0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;
      case (state_q)
        BK_CHECK: begin
          if (err_q == ST_OK) begin
            if (rows_q == RW'(MAX_ROWS)) begin
              err_q <= ST_OVERFLOW;
            end else if (rows_q == '0 && cur_q.coef_diag == '0) begin
              err_q <= ST_ZERO_PIVOT;
            end
          end
        end
        BK_BET: if (bet == '0) err_q <= ST_ZERO_PIVOT;
        BK_DIV_D: begin
          if (div_done) begin
            pivot_q <= bet_q;
            pvup_q  <= cur_q.coef_upper;
            rows_q  <= rows_q + RW'(1);
          end
        end
        BK_FIN: begin
          if (cur_q.last_row) begin
            if (err_q != ST_OK) begin
              res_valid_q       <= 1'b1;
              res_q.solution    <= '0;
              res_q.row_index   <= '0;
              res_q.status      <= err_q;
              res_q.last_result <= 1'b1;
              err_q   <= ST_OK;
              rows_q  <= '0;
              pivot_q <= '0;
              pvup_q  <= '0;
            end else begin
              idx_q   <= IW'(rows_q - RW'(1));
              first_q <= 1'b1;
            end
          end
        end
        BK_BS_OUT: begin
          res_valid_q       <= 1'b1;
          res_q.solution    <= xnew;
          res_q.row_index   <= 6'(idx_q);
          res_q.status      <= ST_OK;
          res_q.last_result <= (idx_q == '0);
          first_q           <= 1'b0;
          if (idx_q == '0) begin
            rows_q  <= '0;
            pivot_q <= '0;
            pvup_q  <= '0;
          end else begin
            idx_q <= idx_q - IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `TSS_ASSERT_NOW(a_err_single, clk_i, rst_ni,
                  res_valid_q && res_q.status != ST_OK,
                  res_q.last_result && res_q.solution == '0)
  `TSS_ASSERT_NOW(a_rows_bound, clk_i, rst_ni, 1'b1, rows_q <= RW'(MAX_ROWS))
  `TSS_ASSERT_NEXT(a_run_cleared, clk_i, rst_ni,
                   res_valid_q && res_q.last_result,
                   rows_q == '0 && err_q == ST_OK)

endmodule

// ===== hw/rtl/tridiagonal_system_solver_unit.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_system_solver_unit
// Streaming Thomas-algorithm solver for tridiagonal systems in signed fixed
// point.
// ----------------------------------------------------------------------------
//  channel   | ports                        | handshake
//  ----------+------------------------------+------------------------------
//  row in    | row_i                        | start_i && !busy_o
//  result    | res_o                        | res_valid_o strobe, one cycle
//
//  A row after the first takes two serial divisions plus control states; the
//  first row needs one division, and a row after an error needs none.
//  After the last row, results come out one at a time, descending.
//  A two-word row queue holds rows while the engine works; busy_o is high
//  when it is full. Reset clears all control state; the factor stores need
//  no clearing.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver_unit
  import tss_pkg::*;
#(
  parameter int unsigned MAX_ROWS  = TssMaxRows,
  parameter int unsigned FRAC_BITS = TssFracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  row_t row_i,
  output logic busy_o,
  output logic res_valid_o,
  output res_t res_o
);

  logic pop, avail;
  row_t head;

  tss_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .row_i  (row_i),
    .busy_o (busy_o),
    .pop_i  (pop),
    .avail_o(avail),
    .head_o (head)
  );

  tss_back #(
    .MAX_ROWS (MAX_ROWS),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .avail_i    (avail),
    .head_i     (head),
    .pop_o      (pop),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

endmodule
